FILE: src/kvlp_pkg.sv
// Package: shared types, constants and character helpers of the key/value line parser.
`timescale 1ns / 1ps

package kvlp_pkg;

    // Parse phase of the current line
    typedef enum logic [2:0] {
        PH_LEAD,
        PH_COMMENT,
        PH_SEEK_KEY,
        PH_KEY,
        PH_SEEK_VALUE,
        PH_VALUE,
        PH_DONE
    } t_phase;

    // Setting codes
    localparam logic [1:0] SEL_NONE    = 2'd0;
    localparam logic [1:0] SEL_IPADDR  = 2'd1;
    localparam logic [1:0] SEL_NETMASK = 2'd2;
    localparam logic [1:0] SEL_GATEWAY = 2'd3;

    // Keyword candidate bits
    localparam int KW_COUNT    = 3;
    localparam int KW_IPADDR   = 0;
    localparam int KW_NETMASK  = 1;
    localparam int KW_GATEWAY  = 2;
    localparam logic [KW_COUNT-1:0] CAND_ALL = 3'b111;

    // Output lanes: 8 in the low word, 7 in the high word
    localparam int LANES      = 15;
    localparam int LOW_LANES  = 8;
    localparam int HIGH_LANES = LANES - LOW_LANES;

    localparam logic [3:0] KEY_LEN_MAX = 4'd15;

    // Special characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Keyword text, zero padded
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"I", "P", "A", "D", "D", "R", 8'h00, 8'h00},
        '{"N", "E", "T", "M", "A", "S", "K", 8'h00},
        '{"G", "A", "T", "E", "W", "A", "Y", 8'h00}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd7, 4'd7};

    // Result handed from the parse core to the output register
    typedef struct packed {
        logic        hit;
        logic [1:0]  setting_select;
        logic [3:0]  value_length;
        logic [63:0] value_low_bytes;
        logic [55:0] value_high_bytes;
        logic        value_truncated;
    } t_result;

    // Digits, letters and dot
    function automatic logic is_word(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || (c == CH_DOT);
    endfunction

    // Space, TAB, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: src/kvlp_if.sv
// Interfaces: character input channel and setting update output channel.
`timescale 1ns / 1ps

interface kvlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       line_end;

    modport source (output valid, output char_code, output line_end, input ready);
    modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface kvlp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  setting_select;
    logic [3:0]  value_length;
    logic [63:0] value_low_bytes;
    logic [55:0] value_high_bytes;
    logic        value_truncated;

    modport source (output valid, output setting_select, output value_length,
                    output value_low_bytes, output value_high_bytes,
                    output value_truncated, input ready);
    modport sink   (input valid, input setting_select, input value_length,
                    input value_low_bytes, input value_high_bytes,
                    input value_truncated, output ready);
endinterface

FILE: src/kvlp_core.sv
// Parse core: per-line state, key matching, value capture and result packing.
`timescale 1ns / 1ps

module kvlp_core #(
    parameter int VALUE_BYTES = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_char,
    input  logic                 i_last,
    output kvlp_pkg::t_result    o_result
);

    kvlp_pkg::t_phase r_phase, n_phase;
    logic [3:0]                     r_key_len, n_key_len;
    logic [kvlp_pkg::KW_COUNT-1:0]  r_cand, n_cand;
    logic [3:0]                     r_count, n_count;
    logic                           r_ovf, n_ovf;
    logic [7:0]                     r_store [VALUE_BYTES];
    logic [7:0]                     n_store [VALUE_BYTES];

    logic nul, word, key_ch, key_fin, val_ch, val_room, hit;
    logic [1:0] sel;
    logic [7:0] lane [kvlp_pkg::LANES];

    // Character class
    assign nul  = (i_char == kvlp_pkg::CH_NUL);
    assign word = kvlp_pkg::is_word(i_char);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (nul) begin
            n_phase = (r_phase == kvlp_pkg::PH_VALUE) ? kvlp_pkg::PH_DONE
                                                      : kvlp_pkg::PH_COMMENT;
        end else begin
            case (r_phase)
                kvlp_pkg::PH_LEAD: begin
                    if (kvlp_pkg::is_space(i_char)) n_phase = kvlp_pkg::PH_LEAD;
                    else if (i_char == kvlp_pkg::CH_HASH) n_phase = kvlp_pkg::PH_COMMENT;
                    else if (word) n_phase = kvlp_pkg::PH_KEY;
                    else n_phase = kvlp_pkg::PH_SEEK_KEY;
                end
                kvlp_pkg::PH_SEEK_KEY: begin
                    if (word) n_phase = kvlp_pkg::PH_KEY;
                end
                kvlp_pkg::PH_KEY: begin
                    if (!word) n_phase = kvlp_pkg::PH_SEEK_VALUE;
                end
                kvlp_pkg::PH_SEEK_VALUE: begin
                    if (word) n_phase = kvlp_pkg::PH_VALUE;
                end
                kvlp_pkg::PH_VALUE: begin
                    if (!word) n_phase = kvlp_pkg::PH_DONE;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Which datapath action this character takes
    assign key_ch  = !nul && word && ((r_phase == kvlp_pkg::PH_LEAD) ||
                     (r_phase == kvlp_pkg::PH_SEEK_KEY) || (r_phase == kvlp_pkg::PH_KEY));
    assign key_fin = (r_phase == kvlp_pkg::PH_KEY) && (nul || !word);
    assign val_ch  = !nul && word && ((r_phase == kvlp_pkg::PH_SEEK_VALUE) ||
                     (r_phase == kvlp_pkg::PH_VALUE));
    assign val_room = (r_count < 4'(VALUE_BYTES));

    // Key matching and value capture
    always_comb begin
        n_cand    = r_cand;
        n_key_len = r_key_len;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_store   = r_store;
        for (int k = 0; k < kvlp_pkg::KW_COUNT; k++) begin
            if (key_ch && ((r_key_len >= kvlp_pkg::KW_LEN[k]) ||
                           (kvlp_pkg::KW_TEXT[k][r_key_len[2:0]] != i_char)))
                n_cand[k] = 1'b0;
            if (key_fin && (r_key_len != kvlp_pkg::KW_LEN[k]))
                n_cand[k] = 1'b0;
        end
        if (key_ch && (r_key_len != kvlp_pkg::KEY_LEN_MAX))
            n_key_len = r_key_len + 4'd1;
        if (val_ch) begin
            if (val_room) begin
                n_count = r_count + 4'd1;
                for (int j = 0; j < VALUE_BYTES; j++) begin
                    if (r_count == 4'(j)) n_store[j] = i_char;
                end
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    // Setting decision at line end
    always_comb begin
        hit = i_last && ((n_phase == kvlp_pkg::PH_VALUE) || (n_phase == kvlp_pkg::PH_DONE)) &&
              (n_count != 4'd0) && (n_cand != '0);
        if (n_cand[kvlp_pkg::KW_IPADDR])       sel = kvlp_pkg::SEL_IPADDR;
        else if (n_cand[kvlp_pkg::KW_NETMASK]) sel = kvlp_pkg::SEL_NETMASK;
        else if (n_cand[kvlp_pkg::KW_GATEWAY]) sel = kvlp_pkg::SEL_GATEWAY;
        else                                   sel = kvlp_pkg::SEL_NONE;
    end

    // Byte lanes; lanes at or above the count read as zero
    for (genvar i = 0; i < kvlp_pkg::LANES; i++) begin : g_lane
        if (i < VALUE_BYTES) begin : g_used
            assign lane[i] = (4'(i) < n_count) ? n_store[i] : 8'h00;
        end else begin : g_unused
            assign lane[i] = 8'h00;
        end
    end

    always_comb begin
        o_result.hit              = hit;
        o_result.setting_select   = sel;
        o_result.value_length     = n_count;
        o_result.value_truncated  = n_ovf;
        for (int i = 0; i < kvlp_pkg::LOW_LANES; i++)
            o_result.value_low_bytes[8*i +: 8] = lane[i];
        for (int i = 0; i < kvlp_pkg::HIGH_LANES; i++)
            o_result.value_high_bytes[8*i +: 8] = lane[kvlp_pkg::LOW_LANES + i];
    end

    // Line state; everything but the value bytes clears at line end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= kvlp_pkg::PH_LEAD;
            r_key_len <= 4'd0;
            r_cand    <= kvlp_pkg::CAND_ALL;
            r_count   <= 4'd0;
            r_ovf     <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_phase   <= kvlp_pkg::PH_LEAD;
                r_key_len <= 4'd0;
                r_cand    <= kvlp_pkg::CAND_ALL;
                r_count   <= 4'd0;
                r_ovf     <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_key_len <= n_key_len;
                r_cand    <= n_cand;
                r_count   <= n_count;
                r_ovf     <= n_ovf;
            end
        end
    end

    // Value bytes
    always_ff @(posedge i_clk) begin
        if (i_step) r_store <= n_store;
    end

endmodule

FILE: src/keyword_value_line_parser.sv
// Top level: input register, parse core and output register of the line parser.
//
//  channel | dir | words                           | handshake
//  i_in    | in  | char_code, line_end             | valid/ready
//  o_out   | out | setting_select, value_length,   | valid/ready
//          |     | value_low/high_bytes, truncated |
//
// One character word per cycle unless a line end waits; a line's update word
// is valid once its last character has passed the input and output registers.
// Reset (synchronous, active low) returns the parser to the start of a line.
// A line end waits in the input register only while the output register still
// holds an untaken update; other characters never stall.
`timescale 1ns / 1ps

module keyword_value_line_parser #(
    parameter int VALUE_BYTES = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    kvlp_in_if.sink             i_in,
    kvlp_out_if.source          o_out
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_char;
    logic             r_last;
    logic             r_out_valid, n_out_valid;
    kvlp_pkg::t_result r_res;
    kvlp_pkg::t_result core_res;
    logic             out_free, advance, in_take;

    // Flow control
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && (!r_last || out_free);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take  = i_in.valid && i_in.ready;

    assign n_in_valid  = in_take || (r_in_valid && !advance);
    assign n_out_valid = (advance && core_res.hit) || (r_out_valid && !o_out.ready);

    kvlp_core #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_char   (r_char),
        .i_last   (r_last),
        .o_result (core_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input word register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_in.char_code;
            r_last <= i_in.line_end;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (advance && core_res.hit) r_res <= core_res;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.setting_select   = r_res.setting_select;
    assign o_out.value_length     = r_res.value_length;
    assign o_out.value_low_bytes  = r_res.value_low_bytes;
    assign o_out.value_high_bytes = r_res.value_high_bytes;
    assign o_out.value_truncated  = r_res.value_truncated;

endmodule
